>>> sv/kdp_pkg.sv
package kdp_pkg;

  // Fixed field widths of the channels and the configuration register
  localparam int unsigned CFG_W      = 6;
  localparam int unsigned WEIGHT_W   = 6;
  localparam int unsigned ITEM_VAL_W = 16;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned OUT_VAL_W  = 32;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_EMIT
  } kdp_state_e;

  // One result item as it leaves the block
  typedef struct packed {
    logic [IDX_W-1:0]     capacity_index;
    logic [OUT_VAL_W-1:0] best_value;
    logic                 last_of_row;
  } kdp_entry_t;

  typedef struct packed {
    logic       push;
    kdp_entry_t entry;
  } kdp_push_t;

  // Output buffer status seen by the sequencer
  typedef struct packed {
    logic [1:0] occ;
    logic       pop;
  } kdp_buf_stat_t;

endpackage

>>> sv/kdp_if.sv
interface kdp_in_if;
  logic                            valid;
  logic                            ready;
  logic [kdp_pkg::WEIGHT_W-1:0]    item_weight;
  logic [kdp_pkg::ITEM_VAL_W-1:0]  item_value;
  logic                            first_item;

  modport source (output valid, output item_weight, output item_value, output first_item,
                  input ready);
  modport sink   (input valid, input item_weight, input item_value, input first_item,
                  output ready);
endinterface

interface kdp_out_if;
  logic                            valid;
  logic                            ready;
  logic [kdp_pkg::IDX_W-1:0]       capacity_index;
  logic [kdp_pkg::OUT_VAL_W-1:0]   best_value;
  logic                            last_of_row;

  modport source (output valid, output capacity_index, output best_value,
                  output last_of_row, input ready);
  modport sink   (input valid, input capacity_index, input best_value,
                  input last_of_row, output ready);
endinterface

>>> sv/knapsack_dp_row_engine_top.sv
// Channel  | Dir | Handshake    | Payload
// in_i     | in  | valid/ready  | item_weight[5:0], item_value[15:0], first_item
// out_o    | out | valid/ready  | capacity_index[5:0], best_value[31:0], last_of_row
// cfg      | in  | cfg_we_i     | cfg_wdata_i[5:0] -> capacity_limit
//
// Per item: a descending update pass over entries L down to 1, then an ascending
// emit pass over entries 0 to L, with L = min(capacity_limit, MAX_CAPACITY), one
// row entry per cycle through the two-read/one-write row memory; an emitted entry
// goes from the registered read port into the output buffer and on to out_o. An
// item with first_item set first clears entries 0 to MAX_CAPACITY. Reset: a
// clearing pass zeroes entries 0 to MAX_CAPACITY; in_i.ready stays low until it
// ends. cfg writes are taken at any time. Output stalls hold the emit pass; a
// two-entry buffer lets emission run at one item per cycle when the sink keeps up.
module knapsack_dp_row_engine_top #(
  parameter int unsigned MAX_CAPACITY = 63,
  parameter int unsigned VALUE_WIDTH  = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [kdp_pkg::CFG_W-1:0]  cfg_wdata_i,
  kdp_in_if.sink                     in_i,
  kdp_out_if.source                  out_o
);
  import kdp_pkg::*;

  localparam int unsigned AW = $clog2(MAX_CAPACITY + 1);

  logic [CFG_W-1:0] cfg_limit_q;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]          mem_raddr_a;
  logic [AW-1:0]          mem_raddr_b;
  logic [VALUE_WIDTH-1:0] mem_rdata_a;
  logic [VALUE_WIDTH-1:0] mem_rdata_b;

  kdp_push_t     push;
  kdp_buf_stat_t buf_stat;
  kdp_entry_t    out_entry;

  // capacity_limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_limit_q <= '0;
    end else if (cfg_we_i) begin
      cfg_limit_q <= cfg_wdata_i;
    end
  end

  // Row store: read c and c-weight, write c back in the next cycle
  kdp_row_mem #(
    .AW (AW),
    .VW (VALUE_WIDTH)
  ) u_row_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  // Sequencer: clear pass, descending update pass, ascending emit pass
  kdp_seq #(
    .MAX_CAPACITY (MAX_CAPACITY),
    .VALUE_WIDTH  (VALUE_WIDTH),
    .AW           (AW)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .in_weight_i   (in_i.item_weight),
    .in_value_i    (in_i.item_value),
    .in_first_i    (in_i.first_item),
    .cfg_limit_i   (cfg_limit_q),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_a_o (mem_raddr_a),
    .mem_raddr_b_o (mem_raddr_b),
    .mem_rdata_a_i (mem_rdata_a),
    .mem_rdata_b_i (mem_rdata_b),
    .push_o        (push),
    .buf_stat_i    (buf_stat)
  );

  // Output buffer decouples the emit pass from the sink
  kdp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .stat_o      (buf_stat),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_entry_o (out_entry)
  );

  assign out_o.capacity_index = out_entry.capacity_index;
  assign out_o.best_value     = out_entry.best_value;
  assign out_o.last_of_row    = out_entry.last_of_row;

endmodule

>>> sv/kdp_row_mem.sv
module kdp_row_mem #(
  parameter int unsigned AW = 6,
  parameter int unsigned VW = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [VW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [VW-1:0] rdata_a_o,
  output logic [VW-1:0] rdata_b_o
);

  localparam int unsigned DEPTH = 1 << AW;

  logic [VW-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Two registered read ports
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

>>> sv/kdp_out_buf.sv
module kdp_out_buf (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  kdp_pkg::kdp_push_t     push_i,
  output kdp_pkg::kdp_buf_stat_t stat_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output kdp_pkg::kdp_entry_t    out_entry_o
);
  import kdp_pkg::*;

  kdp_entry_t entries_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] occ_q, occ_d;
  logic       pop;

  assign out_valid_o = (occ_q != 2'd0);
  assign out_entry_o = entries_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign stat_o.occ  = occ_q;
  assign stat_o.pop  = pop;

  always_comb begin
    wr_ptr_d = push_i.push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    occ_d    = occ_q + {1'b0, push_i.push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      occ_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      occ_q    <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      entries_q[wr_ptr_q] <= push_i.entry;
    end
  end

endmodule

>>> sv/kdp_seq.sv
module kdp_seq #(
  parameter int unsigned MAX_CAPACITY = 63,
  parameter int unsigned VALUE_WIDTH  = 32,
  parameter int unsigned AW           = 6
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [kdp_pkg::WEIGHT_W-1:0]    in_weight_i,
  input  logic [kdp_pkg::ITEM_VAL_W-1:0]  in_value_i,
  input  logic                            in_first_i,
  input  logic [kdp_pkg::CFG_W-1:0]       cfg_limit_i,
  output logic                            mem_we_o,
  output logic [AW-1:0]                   mem_waddr_o,
  output logic [VALUE_WIDTH-1:0]          mem_wdata_o,
  output logic [AW-1:0]                   mem_raddr_a_o,
  output logic [AW-1:0]                   mem_raddr_b_o,
  input  logic [VALUE_WIDTH-1:0]          mem_rdata_a_i,
  input  logic [VALUE_WIDTH-1:0]          mem_rdata_b_i,
  output kdp_pkg::kdp_push_t              push_o,
  input  kdp_pkg::kdp_buf_stat_t          buf_stat_i
);
  import kdp_pkg::*;

  localparam int unsigned CW0 = (AW > WEIGHT_W) ? AW : WEIGHT_W;
  localparam int unsigned CW  = (CW0 > CFG_W) ? CW0 : CFG_W;
  localparam int unsigned SW  = ((VALUE_WIDTH > ITEM_VAL_W) ? VALUE_WIDTH : ITEM_VAL_W) + 1;
  localparam logic [AW-1:0]          LAST_ADDR = AW'(MAX_CAPACITY);
  localparam logic [VALUE_WIDTH-1:0] TOP       = '1;

  kdp_state_e            state_q, state_d;
  logic [AW-1:0]         cnt_q, cnt_d;
  logic [AW-1:0]         lim_q;
  logic [WEIGHT_W-1:0]   w_q;
  logic [ITEM_VAL_W-1:0] v_q;
  logic                  pend_q, pend_d;
  logic                  s1_valid_q, s1_valid_d;
  logic                  s1_fits_q, s1_fits_d;
  logic [AW-1:0]         s1_addr_q, s1_addr_d;
  logic                  rd_pend_q, rd_pend_d;
  logic [IDX_W-1:0]      tag_idx_q, tag_idx_d;
  logic                  tag_last_q, tag_last_d;

  logic                   accept;
  logic [AW-1:0]          lim_eff;
  logic                   fits;
  logic [CW-1:0]          diff;
  logic [CW-1:0]          cnt_ext;
  logic [SW-1:0]          sum;
  logic [VALUE_WIDTH-1:0] cand;
  logic                   upd_we;
  logic [2:0]             load;
  logic                   credit;
  logic [OUT_VAL_W-1:0]   best_out;

  assign accept = in_valid_i && in_ready_o;

  // Limit clipped to the row size
  assign lim_eff = (CW'(cfg_limit_i) > CW'(MAX_CAPACITY)) ? LAST_ADDR : AW'(cfg_limit_i);

  assign cnt_ext       = CW'(cnt_q);
  assign fits          = cnt_ext >= CW'(w_q);
  assign diff          = cnt_ext - CW'(w_q);
  assign mem_raddr_a_o = cnt_q;
  assign mem_raddr_b_o = diff[AW-1:0];

  // Write-back stage: saturating candidate against the old entry
  assign sum    = SW'(mem_rdata_b_i) + SW'(v_q);
  assign cand   = (sum > SW'(TOP)) ? TOP : sum[VALUE_WIDTH-1:0];
  assign upd_we = s1_valid_q && s1_fits_q && (cand > mem_rdata_a_i);

  assign mem_we_o    = (state_q == ST_CLEAR) || upd_we;
  assign mem_waddr_o = (state_q == ST_CLEAR) ? cnt_q : s1_addr_q;
  assign mem_wdata_o = (state_q == ST_CLEAR) ? '0 : cand;

  // Room in the output buffer once the read in flight has landed
  assign load   = 3'(buf_stat_i.occ) + 3'(rd_pend_q);
  assign credit = buf_stat_i.pop ? (load <= 3'd2) : (load <= 3'd1);

  generate
    if (VALUE_WIDTH > OUT_VAL_W) begin : g_clip
      assign best_out = (|mem_rdata_a_i[VALUE_WIDTH-1:OUT_VAL_W]) ? '1
                                                                 : mem_rdata_a_i[OUT_VAL_W-1:0];
    end else begin : g_ext
      assign best_out = OUT_VAL_W'(mem_rdata_a_i);
    end
  endgenerate

  assign push_o.push                 = rd_pend_q;
  assign push_o.entry.capacity_index = tag_idx_q;
  assign push_o.entry.best_value     = best_out;
  assign push_o.entry.last_of_row    = tag_last_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    pend_d     = pend_q;
    s1_valid_d = 1'b0;
    s1_fits_d  = s1_fits_q;
    s1_addr_d  = s1_addr_q;
    rd_pend_d  = 1'b0;
    tag_idx_d  = tag_idx_q;
    tag_last_d = tag_last_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_ADDR) begin
          if (pend_q) begin
            pend_d = 1'b0;
            if (lim_q == '0) begin
              state_d = ST_EMIT;
              cnt_d   = '0;
            end else begin
              state_d = ST_UPDATE;
              cnt_d   = lim_q;
            end
          end else begin
            state_d = ST_IDLE;
            cnt_d   = '0;
          end
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_first_i) begin
            state_d = ST_CLEAR;
            cnt_d   = '0;
            pend_d  = 1'b1;
          end else if (lim_eff == '0) begin
            state_d = ST_EMIT;
            cnt_d   = '0;
          end else begin
            state_d = ST_UPDATE;
            cnt_d   = lim_eff;
          end
        end
      end
      ST_UPDATE: begin
        s1_valid_d = 1'b1;
        s1_fits_d  = fits;
        s1_addr_d  = cnt_q;
        cnt_d      = cnt_q - 1'b1;
        if (cnt_q == AW'(1)) begin
          state_d = ST_EMIT;
          cnt_d   = '0;
        end
      end
      ST_EMIT: begin
        if (credit) begin
          rd_pend_d  = 1'b1;
          tag_idx_d  = cnt_ext[IDX_W-1:0];
          tag_last_d = (cnt_q == lim_q);
          cnt_d      = cnt_q + 1'b1;
          if (cnt_q == lim_q) begin
            state_d = ST_IDLE;
            cnt_d   = '0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      cnt_q      <= '0;
      pend_q     <= 1'b0;
      s1_valid_q <= 1'b0;
      rd_pend_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      pend_q     <= pend_d;
      s1_valid_q <= s1_valid_d;
      rd_pend_q  <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_fits_q  <= s1_fits_d;
    s1_addr_q  <= s1_addr_d;
    tag_idx_q  <= tag_idx_d;
    tag_last_q <= tag_last_d;
    if (accept) begin
      w_q   <= in_weight_i;
      v_q   <= in_value_i;
      lim_q <= lim_eff;
    end
  end

`ifndef SYNTHESIS
  a_idle_no_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !s1_valid_q)
    else $error("write-back pending while idle");

  a_entry0_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_we |-> (s1_addr_q != '0))
    else $error("update wrote capacity zero");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.push |-> ((buf_stat_i.occ != 2'd2) || buf_stat_i.pop))
    else $error("push into full output buffer");

  // Only a fitting capacity uses its c-weight read
  a_no_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_we && (state_q == ST_UPDATE) && fits) |-> (mem_raddr_b_o != s1_addr_q))
    else $error("read of entry being written");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (!s1_valid_q && !rd_pend_q))
    else $error("clear pass overlaps row traffic");
`endif

endmodule
